// File: rtl/dcst_pkg.sv
// Shared types and constants for the drift-calibrated seconds timekeeper.
package dcst_pkg;

  localparam int unsigned SEC_W        = 32;
  localparam int unsigned INTERVAL_W   = 21;
  localparam int unsigned FACTOR_W     = 32;
  localparam int unsigned FRAC_W       = 24;
  localparam int unsigned SERIAL_STEPS = 32;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 21'd60;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef logic [SEC_W-1:0] sec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_RAW,
    ST_MSTART,
    ST_MUL,
    ST_OUT
  } state_e;

endpackage

// File: rtl/dcst_div.sv
// Bit-serial restoring divider: {hi, lo} / divisor, one quotient bit per cycle, hi < divisor.
module dcst_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dcst_pkg::sec_t hi_i,
  input  dcst_pkg::sec_t lo_i,
  input  dcst_pkg::sec_t divisor_i,
  output logic          done_o,
  output dcst_pkg::sec_t quot_o
);
  import dcst_pkg::*;

  localparam int unsigned CNT_W = $clog2(SERIAL_STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  sec_t             rem_q, rem_d;
  sec_t             lo_q;
  sec_t             div_q;
  sec_t             quot_q;
  logic [SEC_W:0]   trial;
  logic [SEC_W:0]   diff;
  logic             take;

  always_comb begin
    trial = {rem_q, lo_q[SEC_W-1]};
    diff  = trial - {1'b0, div_q};
    take  = ~diff[SEC_W];
    rem_d = take ? diff[SEC_W-1:0] : trial[SEC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(SERIAL_STEPS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(SERIAL_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi_i;
      lo_q  <= lo_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      lo_q   <= {lo_q[SEC_W-2:0], 1'b0};
      quot_q <= {quot_q[SEC_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/dcst_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, full-width product.
module dcst_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  dcst_pkg::sec_t             a_i,
  input  dcst_pkg::sec_t             b_i,
  output logic                       done_o,
  output logic [2*dcst_pkg::SEC_W-1:0] product_o
);
  import dcst_pkg::*;

  localparam int unsigned CNT_W = $clog2(SERIAL_STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  sec_t             hi_q;
  sec_t             lo_q;
  sec_t             b_q;
  logic [SEC_W:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(SERIAL_STEPS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(SERIAL_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= a_i;
      b_q  <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[SEC_W:1];
      lo_q <= {sum[0], lo_q[SEC_W-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

// File: rtl/drift_calibrated_seconds_timekeeper_core.sv
// Top level of the drift-calibrated seconds timekeeper.
// Counts epoch seconds from a tick command and returns raw and drift-corrected time, one result
// per input transaction. Items are handled one at a time. While uncalibrated, a tick or read holds
// the input through the RAW, MSTART and OUT states; OUT registers its result. Once a drift factor is
// held, a MUL state is added for the 32-step bit-serial multiply for the correction. A set-time
// command with a nonzero previous set time adds PREP and DIV for the 32-step bit-serial restoring
// divide that derives the Q8.24 factor, or only PREP when the ratio is rejected without dividing.
// The next transaction is accepted while a result waits in the output register. The interval
// register may be written only while no transaction is in flight.
module drift_calibrated_seconds_timekeeper_core #(
  parameter int unsigned TICKS_PER_SECOND = 8,
  parameter int unsigned TICK_COUNT_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dcst_pkg::INTERVAL_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic [31:0]                       new_epoch_seconds_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [31:0]                       raw_seconds_o,
  output logic [31:0]                       corrected_seconds_o,
  output logic                              interval_event_o,
  output logic                              is_calibrated_o
);
  import dcst_pkg::*;

  localparam int unsigned TCB   = TICK_COUNT_BITS;
  localparam int unsigned SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int unsigned TGT_W = INTERVAL_W + 16;
  localparam logic [TGT_W-1:0] TGT_RST_FULL =
    TGT_W'(INTERVAL_RESET) * TGT_W'(TICKS_PER_SECOND);

  state_e                  state_q, state_d;
  sec_t                    base_q, base_d;
  logic [TCB-1:0]          tick_q, tick_d;
  logic [SUB_W-1:0]        sub_q, sub_d;
  logic [TCB-1:0]          sec_q, sec_d;
  sec_t                    last_q, last_d;
  logic [FACTOR_W-1:0]     factor_q, factor_d;
  logic [INTERVAL_W-1:0]   interval_q, interval_d;
  logic [TCB-1:0]          target_q, target_d;
  logic                    event_q, event_d;
  sec_t                    new_q, new_d;
  sec_t                    raw_q, raw_d;
  sec_t                    corr_q, corr_d;
  logic                    out_valid_q, out_valid_d;
  sec_t                    out_raw_q, out_raw_d;
  sec_t                    out_corr_q, out_corr_d;
  logic                    out_event_q, out_event_d;
  logic                    out_cal_q, out_cal_d;

  logic                    in_acc;
  logic                    out_free;
  logic [TCB-1:0]          tick_nx;
  logic [TGT_W-1:0]        tgt_full;
  logic [SEC_W:0]          d_diff, u_diff;
  sec_t                    ad, au;
  logic                    ovf, bad;
  logic                    div_start, div_done;
  sec_t                    div_quot;
  logic                    mul_start, mul_done;
  logic [2*SEC_W-1:0]      product;
  logic [SEC_W+8:0]        corr_sum;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tick_nx    = tick_q + 1'b1;
  assign tgt_full   = TGT_W'(cfg_wdata_i) * TGT_W'(TICKS_PER_SECOND);

  always_comb begin
    d_diff = {1'b0, new_q} - {1'b0, last_q};
    u_diff = {1'b0, base_q} - {1'b0, last_q};
    ad     = d_diff[SEC_W] ? SEC_W'(-d_diff) : d_diff[SEC_W-1:0];
    au     = u_diff[SEC_W] ? SEC_W'(-u_diff) : u_diff[SEC_W-1:0];
    ovf    = {8'b0, ad} >= {au, 8'b0};
    bad    = (u_diff == '0) || (d_diff == '0) || (d_diff[SEC_W] != u_diff[SEC_W]) || ovf;
  end

  assign div_start = (state_q == ST_PREP) && !bad;
  assign mul_start = (state_q == ST_MSTART) && (factor_q != '0);
  assign corr_sum  = {9'b0, last_q} + {1'b0, product[2*SEC_W-1:FRAC_W]}
                   + (SEC_W+9)'(product[FRAC_W-1]);

  dcst_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .hi_i      ({8'b0, ad[SEC_W-1:8]}),
    .lo_i      ({ad[7:0], {FRAC_W{1'b0}}}),
    .divisor_i (au),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  dcst_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (raw_q - last_q),
    .b_i       (factor_q),
    .done_o    (mul_done),
    .product_o (product)
  );

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    tick_d      = tick_q;
    sub_d       = sub_q;
    sec_d       = sec_q;
    last_d      = last_q;
    factor_d    = factor_q;
    interval_d  = interval_q;
    target_d    = target_q;
    event_d     = event_q;
    new_d       = new_q;
    raw_d       = raw_q;
    corr_d      = corr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_raw_d   = out_raw_q;
    out_corr_d  = out_corr_q;
    out_event_d = out_event_q;
    out_cal_d   = out_cal_q;

    if (cfg_we_i) begin
      interval_d = cfg_wdata_i;
      target_d   = tgt_full[TCB-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          event_d = 1'b0;
          new_d   = new_epoch_seconds_i;
          state_d = ST_RAW;
          if (cmd_i == CMD_TICK) begin
            if (tick_nx == target_q) begin
              tick_d  = '0;
              sub_d   = '0;
              sec_d   = '0;
              base_d  = base_q + SEC_W'(interval_q);
              event_d = 1'b1;
            end else if (tick_nx == '0) begin
              tick_d = '0;
              sub_d  = '0;
              sec_d  = '0;
            end else begin
              tick_d = tick_nx;
              if (sub_q == SUB_W'(TICKS_PER_SECOND - 1)) begin
                sub_d = '0;
                sec_d = sec_q + 1'b1;
              end else begin
                sub_d = sub_q + 1'b1;
              end
            end
          end else if (cmd_i == CMD_SET) begin
            if (last_q != '0) begin
              state_d = ST_PREP;
            end else begin
              base_d = new_epoch_seconds_i;
              last_d = new_epoch_seconds_i;
              tick_d = '0;
              sub_d  = '0;
              sec_d  = '0;
            end
          end
        end
      end
      ST_PREP: begin
        if (bad) begin
          factor_d = '0;
          base_d   = new_q;
          last_d   = new_q;
          tick_d   = '0;
          sub_d    = '0;
          sec_d    = '0;
          state_d  = ST_RAW;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          factor_d = div_quot;
          base_d   = new_q;
          last_d   = new_q;
          tick_d   = '0;
          sub_d    = '0;
          sec_d    = '0;
          state_d  = ST_RAW;
        end
      end
      ST_RAW: begin
        raw_d   = base_q + SEC_W'(sec_q);
        state_d = ST_MSTART;
      end
      ST_MSTART: begin
        if (factor_q == '0) begin
          corr_d  = raw_q;
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          corr_d  = (corr_sum[SEC_W+8:SEC_W] != '0) ? '1 : corr_sum[SEC_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_raw_d   = raw_q;
          out_corr_d  = corr_q;
          out_event_d = event_q;
          out_cal_d   = (factor_q != '0);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      tick_q      <= '0;
      sub_q       <= '0;
      sec_q       <= '0;
      last_q      <= '0;
      factor_q    <= '0;
      interval_q  <= INTERVAL_RESET;
      target_q    <= TGT_RST_FULL[TCB-1:0];
      event_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      tick_q      <= tick_d;
      sub_q       <= sub_d;
      sec_q       <= sec_d;
      last_q      <= last_d;
      factor_q    <= factor_d;
      interval_q  <= interval_d;
      target_q    <= target_d;
      event_q     <= event_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q       <= new_d;
    raw_q       <= raw_d;
    corr_q      <= corr_d;
    out_raw_q   <= out_raw_d;
    out_corr_q  <= out_corr_d;
    out_event_q <= out_event_d;
    out_cal_q   <= out_cal_d;
  end

  assign out_valid_o         = out_valid_q;
  assign raw_seconds_o       = out_raw_q;
  assign corrected_seconds_o = out_corr_q;
  assign interval_event_o    = out_event_q;
  assign is_calibrated_o     = out_cal_q;

endmodule
